[src/lin_rx_pkg.sv]
`timescale 1ns / 1ps

package lin_rx_pkg;

  // Frame layout
  localparam int PAYLOAD_LEN    = 8;
  localparam int NUM_BYTES      = 8;
  localparam int POS_W          = 4;
  localparam int IDX_W          = 3;
  localparam int SYNC_SKIP_MAX  = 3;
  localparam int SKIP_W         = 2;
  localparam int ID_COUNT_MAX   = 6;
  localparam int ID_COUNT_W     = 3;
  localparam int TIMEOUT_W      = 20;

  localparam logic [7:0] SYNC_BYTE = 8'h55;
  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam logic [TIMEOUT_W-1:0] TICK_MAX      = '1;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd5313;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_US     = 2'd1;

  // Result status codes
  localparam logic [1:0] STATUS_GOOD     = 2'd0;
  localparam logic [1:0] STATUS_PARITY   = 2'd1;
  localparam logic [1:0] STATUS_CHECKSUM = 2'd2;
  localparam logic [1:0] STATUS_TIMEOUT  = 2'd3;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    logic       framing_error;
  } lin_rx_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] frame_id;
    logic [3:0] length;
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] byte_three;
    logic [7:0] byte_four;
    logic [7:0] byte_five;
    logic [7:0] byte_six;
    logic [7:0] byte_seven;
    logic       rate_confirmed;
  } lin_rx_out_t;

  typedef struct packed {
    logic                 timeout_enable;
    logic [TIMEOUT_W-1:0] timeout_us;
  } lin_rx_cfg_t;

  typedef struct packed {
    logic        emit;
    lin_rx_out_t data;
  } lin_rx_res_t;

  // Ones' complement (end-around carry) byte add
  function automatic logic [7:0] eac_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

  function automatic logic parity_ok(input logic [7:0] p);
    logic [5:0] id;
    logic       b0;
    logic       b1;
    id = p[5:0];
    b0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    b1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return p == {b1, b0, id};
  endfunction

endpackage

[src/lin_frame_receiver.sv]
`timescale 1ns / 1ps
// Path: the byte that closes a frame is held in the input register, then parsed straight into
//   the result register, which offers the result beat.
// Throughput: one item (byte or tick) per cycle; the parser takes the input register each
//   cycle that the result register is empty or being drained.
// Reset (rst_ni low, async): waiting for break, counters and timer cleared, timeout disabled,
//   timeout_us back to 5313. The payload store is not reset.

module lin_frame_receiver (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Item channel: UART bytes and microsecond ticks
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  lin_rx_pkg::lin_rx_in_t                in_data_i,
  // Result channel: one beat per reported frame
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output lin_rx_pkg::lin_rx_out_t               out_data_o,
  // Configuration writes
  input  logic                                  cfg_we_i,
  input  logic [lin_rx_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lin_rx_pkg::TIMEOUT_W-1:0]      cfg_data_i
);
  import lin_rx_pkg::*;

  lin_rx_cfg_t cfg_q;
  lin_rx_in_t  item;
  lin_rx_res_t res;
  logic        item_valid;
  logic        take;
  logic        fire;

  // Config registers; writes to unknown indexes fall away
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_enable <= 1'b0;
      cfg_q.timeout_us     <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TIMEOUT_ENABLE: cfg_q.timeout_enable <= cfg_data_i[0];
        CFG_TIMEOUT_US:     cfg_q.timeout_us     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The parser consumes the held beat whenever the result register can take a result
  assign fire = item_valid & take;

  lin_rx_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  lin_rx_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  lin_rx_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_i       (res),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[src/lin_rx_in_stage.sv]
`timescale 1ns / 1ps

module lin_rx_in_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  lin_rx_pkg::lin_rx_in_t in_data_i,
  input  logic                   take_i,
  output logic                   item_valid_o,
  output lin_rx_pkg::lin_rx_in_t item_o
);
  import lin_rx_pkg::*;

  logic       valid_q;
  lin_rx_in_t item_q;
  logic       load;

  // Held beat leaves when the parser takes it; a new one may enter the same cycle.
  assign in_stall_o   = valid_q & ~take_i;
  assign load         = ~in_stall_o;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      item_q <= in_data_i;
    end
  end

endmodule

[src/lin_rx_parser.sv]
`timescale 1ns / 1ps

module lin_rx_parser (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    fire_i,
  input  lin_rx_pkg::lin_rx_in_t  item_i,
  input  lin_rx_pkg::lin_rx_cfg_t cfg_i,
  output lin_rx_pkg::lin_rx_res_t res_o
);
  import lin_rx_pkg::*;

  typedef enum logic [1:0] {
    PH_WAIT_BREAK,
    PH_ID,
    PH_DATA,
    PH_CHECK
  } phase_e;

  phase_e                  phase_q, phase_d;
  logic                    break_q, break_d;
  logic [SKIP_W-1:0]       skip_q, skip_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic [7:0]              id_q, id_d;
  logic [7:0]              prev_q, prev_d;
  logic                    timer_q, timer_d;
  logic [TIMEOUT_W-1:0]    ticks_q, ticks_d;
  logic [ID_COUNT_W-1:0]   idcnt_q, idcnt_d;
  logic [7:0]              sum_q, sum_d;       // sum of all stored bytes
  logic [7:0]              sum_prev_q, sum_prev_d; // sum without the latest byte
  logic [7:0]              last_q, last_d;
  logic [7:0]              payload_q [NUM_BYTES];
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_idx;
  logic                    emit;
  logic [1:0]              status;
  logic [3:0]              length;
  logic [7:0]              masked [NUM_BYTES];

  always_comb begin
    logic              bp;
    logic [SKIP_W-1:0] sk;
    phase_e            ph;
    logic              done;
    logic [7:0]        d;
    phase_d    = phase_q;
    break_d    = break_q;
    skip_d     = skip_q;
    pos_d      = pos_q;
    id_d       = id_q;
    prev_d     = prev_q;
    timer_d    = timer_q;
    ticks_d    = ticks_q;
    idcnt_d    = idcnt_q;
    sum_d      = sum_q;
    sum_prev_d = sum_prev_q;
    last_d     = last_q;
    wr_en      = 1'b0;
    wr_idx     = pos_q[IDX_W-1:0];
    emit       = 1'b0;
    status     = STATUS_GOOD;
    length     = 4'd0;
    bp         = break_q;
    sk         = skip_q;
    ph         = phase_q;
    done       = 1'b0;
    d          = item_i.rx_byte;

    if (fire_i) begin
      if (item_i.func) begin
        // Microsecond tick
        if (timer_q && ticks_q != TICK_MAX) begin
          ticks_d = ticks_q + 1'b1;
        end
        if (cfg_i.timeout_enable && timer_q &&
            (phase_q == PH_DATA || phase_q == PH_CHECK) &&
            ticks_d > cfg_i.timeout_us) begin
          if (pos_q > POS_W'(1)) begin
            // Latest byte taken as checksum over the bytes before it
            if (last_q == ~eac_add(id_q, sum_prev_q) || last_q == ~sum_prev_q) begin
              emit   = 1'b1;
              status = STATUS_TIMEOUT;
              length = pos_q - 1'b1;
            end
          end else begin
            emit   = 1'b1;
            status = STATUS_TIMEOUT;
            length = 4'd0;
          end
          break_d = 1'b0;
          skip_d  = '0;
          phase_d = PH_WAIT_BREAK;
          pos_d   = '0;
          timer_d = 1'b0;
        end
      end else begin
        // Received byte: break detection first
        if (item_i.framing_error && prev_q == ZERO_BYTE) begin
          bp = 1'b1;
          sk = '0;
        end
        if (bp) begin
          if (d == SYNC_BYTE && prev_q == ZERO_BYTE) begin
            bp      = 1'b0;
            ph      = PH_ID;
            pos_d   = '0;
            id_d    = 8'd0;
            timer_d = 1'b0;
            done    = 1'b1;
          end else if (d == ZERO_BYTE && sk < SKIP_W'(SYNC_SKIP_MAX)) begin
            sk   = sk + 1'b1;
            done = 1'b1;
          end else begin
            bp = 1'b0;
            ph = PH_WAIT_BREAK;
          end
        end
        break_d = bp;
        skip_d  = sk;
        phase_d = ph;

        if (!done) begin
          prev_d = d;
          case (ph)
            PH_ID: begin
              id_d = d;
              if (!parity_ok(d)) begin
                phase_d = PH_WAIT_BREAK;
                emit    = 1'b1;
                status  = STATUS_PARITY;
              end else begin
                if (idcnt_q < ID_COUNT_W'(ID_COUNT_MAX)) begin
                  idcnt_d = idcnt_q + 1'b1;
                end
                pos_d      = '0;
                timer_d    = 1'b1;
                ticks_d    = '0;
                sum_d      = 8'd0;
                sum_prev_d = 8'd0;
                phase_d    = PH_DATA;
              end
            end
            PH_DATA: begin
              if (pos_q >= POS_W'(NUM_BYTES)) begin
                phase_d = PH_WAIT_BREAK;
              end else begin
                wr_en      = 1'b1;
                last_d     = d;
                sum_prev_d = sum_q;
                sum_d      = eac_add(sum_q, d);
                pos_d      = pos_q + 1'b1;
                if (pos_d >= POS_W'(PAYLOAD_LEN)) begin
                  phase_d = PH_CHECK;
                end
              end
            end
            PH_CHECK: begin
              phase_d = PH_WAIT_BREAK;
              emit    = 1'b1;
              if (d == ~eac_add(id_q, sum_q) || d == ~sum_q) begin
                status = STATUS_GOOD;
                length = (d != ZERO_BYTE) ? 4'(PAYLOAD_LEN) : 4'(PAYLOAD_LEN - 1);
              end else begin
                status = STATUS_CHECKSUM;
              end
              pos_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_WAIT_BREAK;
      break_q    <= 1'b0;
      skip_q     <= '0;
      pos_q      <= '0;
      id_q       <= 8'd0;
      prev_q     <= 8'd0;
      timer_q    <= 1'b0;
      ticks_q    <= '0;
      idcnt_q    <= '0;
      sum_q      <= 8'd0;
      sum_prev_q <= 8'd0;
      last_q     <= 8'd0;
    end else begin
      phase_q    <= phase_d;
      break_q    <= break_d;
      skip_q     <= skip_d;
      pos_q      <= pos_d;
      id_q       <= id_d;
      prev_q     <= prev_d;
      timer_q    <= timer_d;
      ticks_q    <= ticks_d;
      idcnt_q    <= idcnt_d;
      sum_q      <= sum_d;
      sum_prev_q <= sum_prev_d;
      last_q     <= last_d;
    end
  end

  // Payload store, no reset: only written entries are ever reported
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      payload_q[wr_idx] <= item_i.rx_byte;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_BYTES; i++) begin
      masked[i] = (4'(i) < length) ? payload_q[i] : 8'd0;
    end
  end

  always_comb begin
    res_o.emit                = emit;
    res_o.data.status         = status;
    res_o.data.frame_id       = id_d[5:0];
    res_o.data.length         = length;
    res_o.data.byte_zero      = masked[0];
    res_o.data.byte_one       = masked[1];
    res_o.data.byte_two       = masked[2];
    res_o.data.byte_three     = masked[3];
    res_o.data.byte_four      = masked[4];
    res_o.data.byte_five      = masked[5];
    res_o.data.byte_six       = masked[6];
    res_o.data.byte_seven     = masked[7];
    res_o.data.rate_confirmed = (idcnt_q >= ID_COUNT_W'(ID_COUNT_MAX));
  end

endmodule

[src/lin_rx_out_stage.sv]
`timescale 1ns / 1ps

module lin_rx_out_stage (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    fire_i,
  input  lin_rx_pkg::lin_rx_res_t res_i,
  output logic                    take_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output lin_rx_pkg::lin_rx_out_t out_data_o
);
  import lin_rx_pkg::*;

  logic        valid_q;
  lin_rx_out_t data_q;

  // Free when empty or when the held beat goes this cycle
  assign take_o      = ~valid_q | ~out_stall_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (fire_i && res_i.emit) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && res_i.emit) begin
      data_q <= res_i.data;
    end
  end

endmodule

[src/lin_rx_checker.sv]
`timescale 1ns / 1ps

module lin_rx_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input lin_rx_pkg::lin_rx_out_t             out_data_o
);
  import lin_rx_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result register");

  a_good_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STATUS_GOOD |->
      out_data_o.length == 4'(PAYLOAD_LEN) || out_data_o.length == 4'(PAYLOAD_LEN - 1))
    else $error("good frame with wrong length");

  a_error_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STATUS_PARITY ||
                    out_data_o.status == STATUS_CHECKSUM) |->
      out_data_o.length == 4'd0 && out_data_o.byte_zero == 8'd0)
    else $error("error frame carries payload");

  a_length_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.length <= 4'(NUM_BYTES))
    else $error("length out of range");

endmodule

bind lin_frame_receiver lin_rx_checker u_lin_rx_checker (.*);
